// ----- rtl/ccv_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and the neighbor table of the color coherence vector block
// no dependencies

package ccv_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int NUM_BINS   = 32;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LC_W   = ADDR_W + 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int QE_W   = ROW_W + COL_W;
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int FR_W   = W_W + H_W;
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int CNT_W  = 17;
  localparam int Q_W    = ROW_W + 1 + W_W + 1;
  localparam int PIX_W  = BIN_W + 1;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN, S_SEED, S_POP, S_POPW, S_NB, S_NEXT,
    S_ACC, S_ACCW, S_EMITR, S_EMITW
  } state_t;

  typedef struct packed {
    logic row_dn;
    logic row_up;
    logic col_dn;
    logic col_up;
  } nb_step_t;

  // neighbor order: row above left to right, same row, row below
  function automatic nb_step_t nb_offset(input logic [2:0] k);
    nb_step_t s;
    s = '0;
    unique case (k)
      3'd0: begin s.row_dn = 1'b1; s.col_dn = 1'b1; end
      3'd1: begin s.row_dn = 1'b1; end
      3'd2: begin s.row_dn = 1'b1; s.col_up = 1'b1; end
      3'd3: begin s.col_dn = 1'b1; end
      3'd4: begin s.col_up = 1'b1; end
      3'd5: begin s.row_up = 1'b1; s.col_dn = 1'b1; end
      3'd6: begin s.row_up = 1'b1; end
      3'd7: begin s.row_up = 1'b1; s.col_up = 1'b1; end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/ccv_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// no dependencies

module ccv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/color_coherence_vector.sv -----
`timescale 1ns / 1ps
// color coherence vector: frame store, region walk, per-bin histogram and result drain
// depends on ccv_pkg and ccv_ram
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------------
//  pixel   | in_valid / in_ready  | pixel_bin, last_pixel
//  config  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  result  | out_valid/out_ready  | bin_index, coherent_count, incoherent_count, last_bin
//
// loading takes one pixel per cycle into the pixel ram
// the walk per pixel: seed scan read and check, queue pop, pop wait, eight pipelined
// neighbor reads of the pixel ram, a drain, a queue check; each region then takes a
// histogram read and a histogram write
// the drain reads each bin, loads it when the output register is free; in_ready is low
// from the frame end until the last bin is loaded into the output register
// visit marks live beside each stored bin and are cleared as the pixel is written
// no clearing pass after reset; cfg_ready is always high

module color_coherence_vector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  pixel_bin,
  input  logic        last_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  bin_index,
  output logic [16:0] coherent_count,
  output logic [16:0] incoherent_count,
  output logic        last_bin
);

  localparam int ADDR_W = ccv_pkg::ADDR_W;
  localparam int LC_W   = ccv_pkg::LC_W;
  localparam int ROW_W  = ccv_pkg::ROW_W;
  localparam int COL_W  = ccv_pkg::COL_W;
  localparam int QE_W   = ccv_pkg::QE_W;
  localparam int W_W    = ccv_pkg::W_W;
  localparam int H_W    = ccv_pkg::H_W;
  localparam int FR_W   = ccv_pkg::FR_W;
  localparam int BIN_W  = ccv_pkg::BIN_W;
  localparam int CNT_W  = ccv_pkg::CNT_W;
  localparam int Q_W    = ccv_pkg::Q_W;
  localparam int PIX_W  = ccv_pkg::PIX_W;

  ccv_pkg::state_t state, state_next;

  logic [CNT_W-1:0] threshold;
  logic [8:0]       width_reg, height_reg;
  logic [W_W-1:0]   w_eff;
  logic [H_W-1:0]   h_eff;
  logic [FR_W-1:0]  frame_size;

  logic [LC_W-1:0]  load_count, lc_inc;
  logic [LC_W-1:0]  scan_p;
  logic [ROW_W-1:0] scan_row, cur_row;
  logic [COL_W-1:0] scan_col, cur_col;
  logic [BIN_W-1:0] color;
  logic [LC_W-1:0]  head, tail;
  logic [3:0]       nb_k;
  logic             s_valid;
  logic [ADDR_W-1:0] s_q;
  logic [ROW_W-1:0] s_row;
  logic [COL_W-1:0] s_col;
  logic [BIN_W-1:0] emit_b;
  logic [ccv_pkg::NUM_BINS-1:0] hist_valid;

  // pixel ram: {visited, bin}
  logic              pix_we, pix_re;
  logic [ADDR_W-1:0] pix_waddr, pix_raddr;
  logic [PIX_W-1:0]  pix_wdata, pix_rdata;
  logic              q_we, q_re;
  logic [ADDR_W-1:0] q_waddr, q_raddr;
  logic [QE_W-1:0]   q_wdata, q_rdata;
  logic              h_we, h_re;
  logic [BIN_W-1:0]  h_waddr, h_raddr;
  logic [2*CNT_W-1:0] h_wdata, h_rdata;
  logic [BIN_W-1:0]  h_rd_addr;

  ccv_ram #(.WIDTH(PIX_W), .DEPTH(ccv_pkg::DEPTH)) u_pix (
    .clk, .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .re(pix_re), .raddr(pix_raddr), .rdata(pix_rdata)
  );
  ccv_ram #(.WIDTH(QE_W), .DEPTH(ccv_pkg::DEPTH)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );
  ccv_ram #(.WIDTH(2*CNT_W), .DEPTH(ccv_pkg::NUM_BINS)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  // effective geometry
  always_comb begin
    if (width_reg == '0) w_eff = W_W'(1);
    else if (32'(width_reg) > ccv_pkg::MAX_WIDTH) w_eff = W_W'(ccv_pkg::MAX_WIDTH);
    else w_eff = W_W'(width_reg);
    if (height_reg == '0) h_eff = H_W'(1);
    else if (32'(height_reg) > ccv_pkg::MAX_HEIGHT) h_eff = H_W'(ccv_pkg::MAX_HEIGHT);
    else h_eff = H_W'(height_reg);
  end
  assign frame_size = FR_W'(w_eff) * FR_W'(h_eff);
  assign lc_inc     = load_count + LC_W'(1);

  logic [BIN_W-1:0] in_bin;
  assign in_bin = (32'(pixel_bin) >= ccv_pkg::NUM_BINS) ?
                  BIN_W'(ccv_pkg::NUM_BINS - 1) : BIN_W'(pixel_bin);

  logic in_fire, frame_end;
  assign in_fire   = in_valid && in_ready;
  assign frame_end = last_pixel || (32'(lc_inc) >= 32'(frame_size)) ||
                     (32'(lc_inc) >= ccv_pkg::DEPTH);

  // neighbor address stage
  ccv_pkg::nb_step_t nb;
  logic [ROW_W:0] nr;
  logic [COL_W:0] nc;
  logic [Q_W-1:0] nq;
  logic           nb_ok, nb_issue;
  always_comb begin
    nb = ccv_pkg::nb_offset(nb_k[2:0]);
    nb_ok = 1'b1;
    if (nb.row_dn && cur_row == '0) nb_ok = 1'b0;
    if (nb.col_dn && cur_col == '0) nb_ok = 1'b0;
    if (nb.col_up && (32'(cur_col) + 1 >= 32'(w_eff))) nb_ok = 1'b0;
    if (nb.row_dn) nr = {1'b0, cur_row} - (ROW_W+1)'(1);
    else if (nb.row_up) nr = {1'b0, cur_row} + (ROW_W+1)'(1);
    else nr = {1'b0, cur_row};
    if (nb.col_dn) nc = {1'b0, cur_col} - (COL_W+1)'(1);
    else if (nb.col_up) nc = {1'b0, cur_col} + (COL_W+1)'(1);
    else nc = {1'b0, cur_col};
    nq = Q_W'(nr) * Q_W'(w_eff) + Q_W'(nc);
    nb_issue = (state == ccv_pkg::S_NB) && !nb_k[3] && nb_ok &&
               (nq < Q_W'(load_count));
  end

  logic nb_hit;
  assign nb_hit = s_valid && !pix_rdata[PIX_W-1] && (pix_rdata[BIN_W-1:0] == color);

  logic scan_last;
  assign scan_last = (scan_p + LC_W'(1)) >= load_count;

  // histogram read with valid masking
  logic [CNT_W-1:0] h_coh, h_inc, size;
  assign h_coh = hist_valid[h_rd_addr] ? h_rdata[2*CNT_W-1:CNT_W] : '0;
  assign h_inc = hist_valid[h_rd_addr] ? h_rdata[CNT_W-1:0] : '0;
  assign size  = CNT_W'(tail);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    pix_we = 1'b0; pix_waddr = '0; pix_wdata = '0;
    pix_re = 1'b0; pix_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0;
    q_re = 1'b0; q_raddr = '0;
    h_we = 1'b0; h_waddr = color; h_wdata = '0;
    h_re = 1'b0; h_raddr = color;
    if (nb_hit) begin
      pix_we = 1'b1; pix_waddr = s_q; pix_wdata = {1'b1, color};
      q_we = (32'(tail) < ccv_pkg::DEPTH);
      q_waddr = tail[ADDR_W-1:0]; q_wdata = {s_row, s_col};
    end
    unique case (state)
      ccv_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pix_we = 1'b1; pix_waddr = load_count[ADDR_W-1:0]; pix_wdata = {1'b0, in_bin};
          if (frame_end) state_next = ccv_pkg::S_SCAN;
        end
      end
      ccv_pkg::S_SCAN: begin
        pix_re = 1'b1; pix_raddr = scan_p[ADDR_W-1:0];
        state_next = ccv_pkg::S_SEED;
      end
      ccv_pkg::S_SEED: begin
        if (pix_rdata[PIX_W-1]) begin
          state_next = scan_last ? ccv_pkg::S_EMITR : ccv_pkg::S_SCAN;
        end else begin
          pix_we = 1'b1; pix_waddr = scan_p[ADDR_W-1:0];
          pix_wdata = {1'b1, pix_rdata[BIN_W-1:0]};
          q_we = 1'b1; q_waddr = '0; q_wdata = {scan_row, scan_col};
          state_next = ccv_pkg::S_POP;
        end
      end
      ccv_pkg::S_POP: begin
        q_re = 1'b1; q_raddr = head[ADDR_W-1:0];
        state_next = ccv_pkg::S_POPW;
      end
      ccv_pkg::S_POPW: state_next = ccv_pkg::S_NB;
      ccv_pkg::S_NB: begin
        if (nb_issue) begin
          pix_re = 1'b1; pix_raddr = nq[ADDR_W-1:0];
        end
        if (nb_k[3]) state_next = ccv_pkg::S_NEXT;
      end
      ccv_pkg::S_NEXT: state_next = (head < tail) ? ccv_pkg::S_POP : ccv_pkg::S_ACC;
      ccv_pkg::S_ACC: begin
        h_re = 1'b1;
        state_next = ccv_pkg::S_ACCW;
      end
      ccv_pkg::S_ACCW: begin
        h_we = 1'b1;
        if (size >= threshold) h_wdata = {h_coh + size, h_inc};
        else h_wdata = {h_coh, h_inc + size};
        state_next = scan_last ? ccv_pkg::S_EMITR : ccv_pkg::S_SCAN;
      end
      ccv_pkg::S_EMITR: begin
        h_re = 1'b1; h_raddr = emit_b;
        state_next = ccv_pkg::S_EMITW;
      end
      ccv_pkg::S_EMITW: begin
        if (out_free) begin
          state_next = (32'(emit_b) == ccv_pkg::NUM_BINS - 1) ?
                       ccv_pkg::S_LOAD : ccv_pkg::S_EMITR;
        end
      end
      default: state_next = ccv_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ccv_pkg::S_LOAD;
    else state <= state_next;
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= CNT_W'(1);
      width_reg  <= 9'd256;
      height_reg <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccv_pkg::REG_THRESHOLD: threshold  <= cfg_data;
        ccv_pkg::REG_WIDTH:     width_reg  <= cfg_data[8:0];
        ccv_pkg::REG_HEIGHT:    height_reg <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      hist_valid <= '0;
      s_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_fire) load_count <= lc_inc;
      if (h_we) hist_valid[h_waddr] <= 1'b1;
      s_valid <= nb_issue;
      if (state == ccv_pkg::S_EMITW && out_free) begin
        out_valid <= 1'b1;
        if (32'(emit_b) == ccv_pkg::NUM_BINS - 1) begin
          hist_valid <= '0;
          load_count <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (h_re) h_rd_addr <= h_raddr;
    s_q   <= nq[ADDR_W-1:0];
    s_row <= nr[ROW_W-1:0];
    s_col <= nc[COL_W-1:0];
    if (nb_hit && (32'(tail) < ccv_pkg::DEPTH)) tail <= tail + LC_W'(1);
    unique case (state)
      ccv_pkg::S_LOAD: begin
        scan_p <= '0; scan_row <= '0; scan_col <= '0; emit_b <= '0;
      end
      ccv_pkg::S_SEED: begin
        if (!pix_rdata[PIX_W-1]) begin
          color <= pix_rdata[BIN_W-1:0];
          head  <= '0;
          tail  <= LC_W'(1);
        end
      end
      ccv_pkg::S_POP: head <= head + LC_W'(1);
      ccv_pkg::S_POPW: begin
        cur_row <= q_rdata[QE_W-1:COL_W];
        cur_col <= q_rdata[COL_W-1:0];
        nb_k    <= '0;
      end
      ccv_pkg::S_NB: if (!nb_k[3]) nb_k <= nb_k + 4'd1;
      ccv_pkg::S_EMITW: begin
        if (out_free) begin
          emit_b    <= emit_b + BIN_W'(1);
          bin_index <= 5'(emit_b);
          last_bin  <= (32'(emit_b) == ccv_pkg::NUM_BINS - 1);
          if (h_coh < threshold) begin
            coherent_count   <= '0;
            incoherent_count <= h_inc + h_coh;
          end else begin
            coherent_count   <= h_coh;
            incoherent_count <= h_inc;
          end
        end
      end
      default: ;
    endcase
    // advance the seed scan in raster order
    if ((state == ccv_pkg::S_SEED && pix_rdata[PIX_W-1]) || state == ccv_pkg::S_ACCW) begin
      scan_p <= scan_p + LC_W'(1);
      if (32'(scan_col) + 1 >= 32'(w_eff)) begin
        scan_col <= '0;
        scan_row <= scan_row + ROW_W'(1);
      end else begin
        scan_col <= scan_col + COL_W'(1);
      end
    end
  end

endmodule

// ----- verif/color_coherence_vector_tb.sv -----
`timescale 1ns / 1ps
// testbench for color_coherence_vector: pixel frames in, one word per color bin out
// depends on ccv_pkg and the color_coherence_vector rtl; self-checking, no files read

module color_coherence_vector_tb;

  localparam int IDLE_LIMIT = 50000;
  localparam int SETTLE = 60;

  typedef struct {
    logic [4:0]  bin;
    logic [16:0] coh;
    logic [16:0] inc;
    logic        lastb;
  } bin_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  pixel_bin = '0;
  logic        last_pixel = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = ccv_pkg::REG_THRESHOLD;
  logic [16:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  bin_index;
  logic [16:0] coherent_count;
  logic [16:0] incoherent_count;
  logic        last_bin;

  color_coherence_vector u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_bin(pixel_bin), .last_pixel(last_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .bin_index(bin_index), .coherent_count(coherent_count),
    .incoherent_count(incoherent_count), .last_bin(last_bin)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block state
  logic [16:0] thr_reg = 17'd1;
  logic [8:0]  width_reg = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic [4:0]  frame_px [ccv_pkg::DEPTH];
  bit          visited [ccv_pkg::DEPTH];
  int unsigned walk_fifo [ccv_pkg::DEPTH];
  int unsigned pixels_held = 0;

  bin_word_t hist_expected [$];
  int errors = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_frames = 0;
  int n_words = 0;
  bit quiet = 1'b0;

  function automatic int unsigned eff_dim(input logic [8:0] r, input int unsigned lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic int unsigned region_size(input int unsigned seed, input int unsigned w,
                                              input int unsigned cnt);
    int unsigned head, tail, p, row, col, q;
    int nr, nc;
    logic [4:0] color;
    head = 0;
    tail = 0;
    color = frame_px[seed];
    visited[seed] = 1'b1;
    walk_fifo[tail++] = seed;
    while (head < tail) begin
      p = walk_fifo[head++];
      row = p / w;
      col = p % w;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          nr = int'(row) + dr;
          nc = int'(col) + dc;
          if (dr == 0 && dc == 0) continue;
          if (nr < 0 || nc < 0 || nc >= int'(w)) continue;
          q = nr * w + nc;
          if (q >= cnt) continue;
          if (visited[q] || frame_px[q] != color) continue;
          visited[q] = 1'b1;
          walk_fifo[tail++] = q;
        end
      end
    end
    return tail;
  endfunction

  function automatic void close_frame();
    logic [16:0] coh_h [ccv_pkg::NUM_BINS];
    logic [16:0] inc_h [ccv_pkg::NUM_BINS];
    int unsigned w, sz;
    bin_word_t r;
    w = eff_dim(width_reg, ccv_pkg::MAX_WIDTH);
    for (int b = 0; b < ccv_pkg::NUM_BINS; b++) begin
      coh_h[b] = '0;
      inc_h[b] = '0;
    end
    for (int unsigned p = 0; p < pixels_held; p++) visited[p] = 1'b0;
    for (int unsigned p = 0; p < pixels_held; p++) begin
      if (!visited[p]) begin
        sz = region_size(p, w, pixels_held);
        if (sz >= thr_reg) coh_h[frame_px[p]] += 17'(sz);
        else inc_h[frame_px[p]] += 17'(sz);
      end
    end
    for (int b = 0; b < ccv_pkg::NUM_BINS; b++) begin
      r.bin = 5'(b);
      r.coh = coh_h[b];
      r.inc = inc_h[b];
      // a bin with too few coherent pixels folds them into incoherent
      if (coh_h[b] < thr_reg) begin
        r.inc = inc_h[b] + coh_h[b];
        r.coh = '0;
      end
      r.lastb = (b == ccv_pkg::NUM_BINS - 1);
      hist_expected.push_back(r);
    end
    pixels_held = 0;
    n_frames++;
  endfunction

  function automatic void take_pixel(input logic [4:0] b, input logic l);
    int unsigned frame_sz;
    frame_sz = eff_dim(width_reg, ccv_pkg::MAX_WIDTH) *
               eff_dim(height_reg, ccv_pkg::MAX_HEIGHT);
    if (pixels_held < ccv_pkg::DEPTH) begin
      frame_px[pixels_held] = (b >= ccv_pkg::NUM_BINS) ? 5'(ccv_pkg::NUM_BINS - 1) : b;
      pixels_held++;
    end
    if (l || pixels_held >= frame_sz || pixels_held >= ccv_pkg::DEPTH) close_frame();
  endfunction

  task automatic send_pixel(input logic [4:0] b, input logic l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_bin <= b;
    last_pixel <= l;
    do @(posedge clk); while (!in_ready);
    take_pixel(b, l);
    n_items++;
  endtask

  // drains results, then lets the block settle so registers can change
  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (hist_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ccv_pkg::REG_THRESHOLD: thr_reg = val;
      ccv_pkg::REG_WIDTH:     width_reg = val[8:0];
      ccv_pkg::REG_HEIGHT:    height_reg = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [16:0] t, input logic [8:0] w, input logic [8:0] h);
    wait_idle();
    write_reg(ccv_pkg::REG_THRESHOLD, t);
    write_reg(ccv_pkg::REG_WIDTH, {8'd0, w});
    write_reg(ccv_pkg::REG_HEIGHT, {8'd0, h});
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall per word unless quiet, checks against the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    bin_word_t e;
    int pick;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (hist_expected.size() == 0) begin
          errors++;
          if (mismatches++ < 10)
            $display("unexpected word: bin %0d coh %0d inc %0d", bin_index, coherent_count,
                     incoherent_count);
        end else begin
          e = hist_expected.pop_front();
          if (bin_index !== e.bin || coherent_count !== e.coh ||
              incoherent_count !== e.inc || last_bin !== e.lastb) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp bin %0d coh %0d inc %0d last %0d, got %0d %0d %0d %0d",
                       e.bin, e.coh, e.inc, e.lastb, bin_index, coherent_count,
                       incoherent_count, last_bin);
          end
        end
      end
      if (out_ready && out_valid) begin
        if (!quiet) begin
          pick = $urandom_range(0, 9);
          stall_left <= pick;
          if (pick > 0) out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (stall_left <= 1) out_ready <= 1'b1;
        stall_left <= stall_left - 1;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    // full 256x256 geometry, so frames end on last_pixel only
    send_pixel(5'd7, 1'b1);
    send_pixel(5'd0, 1'b0);
    send_pixel(5'd31, 1'b0);
    send_pixel(5'd0, 1'b1);
  endtask

  task automatic test_small_geometry();
    // column of four: width zero acts as one
    set_geometry(17'd2, 9'd0, 9'd4);
    send_pixel(5'd3, 1'b0);
    send_pixel(5'd3, 1'b0);
    send_pixel(5'd9, 1'b0);
    send_pixel(5'd3, 1'b0);
    // 3x3 with a diagonal chain, ends on the count
    set_geometry(17'd3, 9'd3, 9'd3);
    send_pixel(5'd1, 1'b0); send_pixel(5'd2, 1'b0); send_pixel(5'd2, 1'b0);
    send_pixel(5'd2, 1'b0); send_pixel(5'd1, 1'b0); send_pixel(5'd2, 1'b0);
    send_pixel(5'd1, 1'b0); send_pixel(5'd2, 1'b0); send_pixel(5'd1, 1'b0);
    // short frame, lower-left neighbor only
    send_pixel(5'd4, 1'b0); send_pixel(5'd5, 1'b0); send_pixel(5'd5, 1'b0);
    send_pixel(5'd4, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    set_geometry(17'd0, 9'd2, 9'd2);
    send_pixel(5'd10, 1'b0); send_pixel(5'd11, 1'b0);
    send_pixel(5'd12, 1'b0); send_pixel(5'd31, 1'b0);
    set_geometry(17'd65536, 9'd2, 9'd2);
    send_pixel(5'd10, 1'b0); send_pixel(5'd10, 1'b0);
    send_pixel(5'd10, 1'b0); send_pixel(5'd10, 1'b0);
  endtask

  task automatic test_wide_frame();
    // width above the maximum clamps to 256, height zero acts as one
    set_geometry(17'd5, 9'd511, 9'd0);
    for (int i = 0; i < ccv_pkg::MAX_WIDTH; i++) send_pixel(5'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, n, cut, span;
    logic [16:0] t;
    while (n_items < 460) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 4))
        0: t = 17'd0;
        1: t = 17'd1;
        2: t = 17'(w * h + 1);
        3: t = 17'd65536;
        default: t = 17'($urandom_range(2, 8));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      set_geometry(t, 9'(w), 9'(h));
      span = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(1, 3);
      for (int f = 0; f < $urandom_range(1, 3); f++) begin
        n = w * h;
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : 0;
        for (int unsigned i = 1; i <= n; i++) begin
          if (cut != 0 && i == cut) begin
            send_pixel(5'($urandom_range(0, span)), 1'b1);
            break;
          end
          send_pixel(5'($urandom_range(0, span)), 1'b0);
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_small_geometry();
    test_threshold_extremes();
    test_wide_frame();
    test_random_frames();
    wait_idle();
    if (hist_expected.size() != 0) errors++;
    $display("%0d pixels in %0d frames, %0d bin words checked", n_items, n_frames, n_words);
    $display("geometry clamps, short frames and threshold extremes exercised");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- color_coherence_vector.f -----
rtl/ccv_pkg.sv
rtl/ccv_ram.sv
rtl/color_coherence_vector.sv
verif/color_coherence_vector_tb.sv
